// ----- src/sha256_stream_hasher_core_defines.svh -----
// assertion helpers used by the hasher back end
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH

`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/sha_pkg.sv -----
package sha_pkg;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_PAD,
    FE_WAIT
  } fe_state_t;

  typedef enum logic [1:0] {
    BE_IDLE,
    BE_ROUND,
    BE_ADD,
    BE_EMIT
  } be_state_t;

  // one queued block job for the back end
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } job_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic       CMD_FEED = 1'b0;
  localparam logic       CMD_FINISH = 1'b1;

endpackage

// ----- src/sha_front.sv -----
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [7:0]        in_byte,
  output logic              job_valid,
  input  logic              job_ready,
  output sha_pkg::job_t     job,
  input  logic              digest_done
);

  sha_pkg::fe_state_t state_r, state_nxt;
  logic [511:0] blk_r, blk_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [60:0]  len_r, len_nxt;
  logic         jv_r, jv_nxt;
  logic         jf_r, jf_nxt;
  logic [511:0] jblk_r, jblk_nxt;
  logic [7:0]   pbyte;
  logic [63:0]  bits;

  assign bits = {len_r, 3'b000};
  assign in_ready = (state_r == sha_pkg::FE_IDLE) && !jv_r;
  assign job_valid = jv_r;
  assign job.block = jblk_r;
  assign job.final_blk = jf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::FE_IDLE;
      fill_r <= '0;
      len_r <= '0;
      jv_r <= 1'b0;
      jf_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r <= fill_nxt;
      len_r <= len_nxt;
      jv_r <= jv_nxt;
      jf_r <= jf_nxt;
    end
    blk_r <= blk_nxt;
    jblk_r <= jblk_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    blk_nxt = blk_r;
    fill_nxt = fill_r;
    len_nxt = len_r;
    jv_nxt = jv_r;
    jf_nxt = jf_r;
    jblk_nxt = jblk_r;
    pbyte = 8'h00;
    if (jv_r && job_ready) jv_nxt = 1'b0;
    case (state_r)
      sha_pkg::FE_IDLE: begin
        if (in_valid && in_ready) begin
          if (in_cmd == sha_pkg::CMD_FEED) begin
            pbyte = in_byte;
            len_nxt = len_r + 61'd1;
          end else begin
            pbyte = sha_pkg::PAD_BYTE;
            state_nxt = sha_pkg::FE_PAD;
          end
          blk_nxt[511 - {fill_r, 3'b000} -: 8] = pbyte;
          fill_nxt = fill_r + 6'd1;
          if (fill_r == 6'd63) begin
            jv_nxt = 1'b1;
            jf_nxt = 1'b0;
            jblk_nxt = blk_nxt;
          end
        end
      end
      sha_pkg::FE_PAD: begin
        // zero fill then length, one byte a cycle, while the queue slot is free
        if (!jv_r) begin
          if (fill_r == sha_pkg::LEN_OFFSET) begin
            blk_nxt[63:0] = bits;
            fill_nxt = '0;
            jv_nxt = 1'b1;
            jf_nxt = 1'b1;
            jblk_nxt = {blk_r[511:64], bits};
            state_nxt = sha_pkg::FE_WAIT;
          end else begin
            blk_nxt[511 - {fill_r, 3'b000} -: 8] = 8'h00;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              jv_nxt = 1'b1;
              jf_nxt = 1'b0;
              jblk_nxt = blk_nxt;
            end
          end
        end
      end
      sha_pkg::FE_WAIT: begin
        len_nxt = '0;
        if (digest_done) begin
          state_nxt = sha_pkg::FE_IDLE;
        end
      end
      default: state_nxt = sha_pkg::FE_IDLE;
    endcase
  end

endmodule

// ----- src/sha_back.sv -----
`include "sha256_stream_hasher_core_defines.svh"
module sha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  sha_pkg::job_t     job,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_word,
  output logic [2:0]        out_idx,
  output logic              out_last,
  output logic              digest_done
);

  sha_pkg::be_state_t state_r, state_nxt;
  logic [255:0] h_r, h_nxt;
  logic [255:0] v_r, v_nxt;
  logic [511:0] w_r, w_nxt;
  logic [5:0]   rnd_r, rnd_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         fin_r, fin_nxt;
  logic [31:0]  a, b, c, d, e, f, g, hh, t1, t2, s0, s1, wn, w1, w14;
  logic         last_rnd, idle_init;

  assign job_ready = (state_r == sha_pkg::BE_IDLE);
  assign out_valid = (state_r == sha_pkg::BE_EMIT);
  assign out_word = h_r[255 - {idx_r, 5'b00000} -: 32];
  assign out_idx = idx_r;
  assign out_last = (idx_r == 3'd7);
  assign digest_done = out_valid && out_ready && out_last;
  assign last_rnd = (state_r == sha_pkg::BE_ROUND) && (rnd_r == 6'd63);
  assign idle_init = (h_r == sha_pkg::H_INIT) && (state_r == sha_pkg::BE_IDLE);

  assign {a, b, c, d, e, f, g, hh} = v_r;
  assign w1 = w_r[479:448];
  assign w14 = w_r[63:32];
  assign s0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign wn = w_r[511:480] + s0 + w_r[223:192] + s1;
  assign t1 = hh + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
            + ((e & f) ^ (~e & g)) + sha_pkg::K_TAB[rnd_r] + w_r[511:480];
  assign t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
            + ((a & b) ^ (a & c) ^ (b & c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::BE_IDLE;
      h_r <= sha_pkg::H_INIT;
      rnd_r <= '0;
      idx_r <= '0;
      fin_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      h_r <= h_nxt;
      rnd_r <= rnd_nxt;
      idx_r <= idx_nxt;
      fin_r <= fin_nxt;
    end
    v_r <= v_nxt;
    w_r <= w_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    h_nxt = h_r;
    v_nxt = v_r;
    w_nxt = w_r;
    rnd_nxt = rnd_r;
    idx_nxt = idx_r;
    fin_nxt = fin_r;
    case (state_r)
      sha_pkg::BE_IDLE: begin
        if (job_valid) begin
          w_nxt = job.block;
          v_nxt = h_r;
          fin_nxt = job.final_blk;
          rnd_nxt = '0;
          state_nxt = sha_pkg::BE_ROUND;
        end
      end
      sha_pkg::BE_ROUND: begin
        // one round a cycle, schedule kept as a 16-word sliding window
        v_nxt = {t1 + t2, a, b, c, d + t1, e, f, g};
        w_nxt = {w_r[479:0], wn};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = sha_pkg::BE_ADD;
      end
      sha_pkg::BE_ADD: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i*32 +: 32] = h_r[i*32 +: 32] + v_r[i*32 +: 32];
        end
        idx_nxt = '0;
        state_nxt = fin_r ? sha_pkg::BE_EMIT : sha_pkg::BE_IDLE;
      end
      sha_pkg::BE_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            h_nxt = sha_pkg::H_INIT;
            state_nxt = sha_pkg::BE_IDLE;
          end
        end
      end
      default: state_nxt = sha_pkg::BE_IDLE;
    endcase
  end

  `SHA_ASSERT_IMP(a_emit_ready, clk, rst_n, out_valid, !job_ready)
  `SHA_ASSERT_NXT(a_round_wrap, clk, rst_n, last_rnd, state_r == sha_pkg::BE_ADD)
  `SHA_ASSERT_NXT(a_done_reset, clk, rst_n, digest_done, idle_init)

endmodule

// ----- src/sha256_stream_hasher_core.sv -----
// rounds: a full block runs 64 rounds, then an add of the working state into the hash
// throughput: 1 byte per cycle while the back end keeps up
// a finish pads one byte a cycle while the job slot is free up to offset 56, then writes the length
// digest: eight words, one per cycle while out_tready is high, after the last block's rounds and add
// reset: synchronous active-low rst_n, hash words back to initial values, counts cleared
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,  // data_byte[7:0]
  input  logic        in_tuser,  // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // digest_word[31:0], word_index[34:32], zero[39:35]
  output logic        out_tlast  // last_word
);

  sha_pkg::job_t job;
  logic job_valid, job_ready, digest_done;
  logic [31:0] word;
  logic [2:0] idx;

  sha_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser), .in_byte(in_tdata),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .digest_done(digest_done)
  );

  sha_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job_ready(job_ready), .job(job),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_word(word), .out_idx(idx), .out_last(out_tlast),
    .digest_done(digest_done)
  );

  assign out_tdata = {5'b00000, idx, word};

endmodule
